>>> design/cle_pkg.sv
`default_nettype none

package cle_pkg;

  localparam int DATA_W = 8;
  localparam int CNT_W = 6;
  localparam int LINE_DEPTH_DEF = 32;

  localparam logic [DATA_W-1:0] KEY_NEWLINE = 8'h0A;
  localparam logic [DATA_W-1:0] KEY_LEFT = 8'h3C;
  localparam logic [DATA_W-1:0] KEY_RIGHT = 8'h3E;
  localparam logic [DATA_W-1:0] KEY_DELETE = 8'h2D;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SHIFT_L = 6'b000010,
    S_SHIFT_R = 6'b000100,
    S_FETCH   = 6'b001000,
    S_EMIT    = 6'b010000,
    S_CLOSE   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

>>> design/cursor_line_editor.sv
// Line editor over a gap buffer of LINE_DEPTH characters held in one single-port-per-direction
// RAM. Inserts, deletes and cursor moves that hit an end of the line are done in S_IDLE; a
// cursor move that shifts a character also passes through S_SHIFT_L or S_SHIFT_R, because
// the character is read through the registered RAM port and written back across the gap. A
// newline drains the line: each character is read in S_FETCH and loaded into the output in
// S_EMIT, then S_CLOSE loads the newline; output stall holds both. Only one item is worked on
// at a time, and key_stall is high until it is done. No clearing pass follows reset.
`default_nettype none

module cursor_line_editor #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       key_valid,
  output logic                            key_stall,
  input  wire logic [cle_pkg::DATA_W-1:0] key_byte,
  output logic                            char_valid,
  input  wire logic                       char_stall,
  output logic      [cle_pkg::DATA_W-1:0] char_out,
  output logic                            last,
  output logic                            overflow
);

  localparam int CW = cle_pkg::CNT_W;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

  cle_pkg::state_t state, state_next;
  logic [CW-1:0] left_count, left_count_next;
  logic [CW-1:0] right_base, right_base_next;
  logic          dropped_flag, dropped_flag_next;
  logic [CW-1:0] idx, idx_next;
  logic          on_right, on_right_next;

  logic [CW-1:0] add_a;
  logic          add_dec;
  logic [CW-1:0] add_sum;

  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [cle_pkg::DATA_W-1:0] rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [cle_pkg::DATA_W-1:0] wr_data;

  logic                       out_free;
  logic                       load_out;
  logic [cle_pkg::DATA_W-1:0] char_out_next;
  logic                       last_next;
  logic                       overflow_next;

  cle_ram #(
    .WIDTH(cle_pkg::DATA_W),
    .DEPTH(LINE_DEPTH)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // The one step unit: every count and address moves by one through this adder.
  always_comb begin
    add_a = left_count;
    add_dec = 1'b0;
    case (state)
      cle_pkg::S_IDLE: begin
        case (key_byte)
          cle_pkg::KEY_LEFT: add_dec = 1'b1;
          cle_pkg::KEY_DELETE: add_dec = 1'b1;
          cle_pkg::KEY_RIGHT: add_a = right_base;
          default: add_a = left_count;
        endcase
      end
      cle_pkg::S_SHIFT_L: begin
        add_a = right_base;
        add_dec = 1'b1;
      end
      cle_pkg::S_FETCH: add_a = idx;
      default: add_a = left_count;
    endcase
  end

  assign add_sum = add_a + (add_dec ? {CW{1'b1}} : CW'(1));

  assign key_stall = (state != cle_pkg::S_IDLE);
  assign out_free = !char_valid || !char_stall;

  always_comb begin
    state_next = state;
    left_count_next = left_count;
    right_base_next = right_base;
    dropped_flag_next = dropped_flag;
    idx_next = idx;
    on_right_next = on_right;
    rd_en = 1'b0;
    rd_addr = left_count[AW-1:0];
    wr_en = 1'b0;
    wr_addr = left_count[AW-1:0];
    wr_data = key_byte;
    load_out = 1'b0;
    char_out_next = rd_data;
    last_next = 1'b0;
    overflow_next = 1'b0;
    case (state)
      cle_pkg::S_IDLE: begin
        if (key_valid) begin
          case (key_byte)
            cle_pkg::KEY_NEWLINE: begin
              idx_next = '0;
              on_right_next = 1'b0;
              state_next = cle_pkg::S_FETCH;
            end
            cle_pkg::KEY_LEFT: begin
              if (left_count != '0) begin
                rd_en = 1'b1;
                rd_addr = add_sum[AW-1:0];
                left_count_next = add_sum;
                state_next = cle_pkg::S_SHIFT_L;
              end
            end
            cle_pkg::KEY_RIGHT: begin
              if (right_base != DEPTH_C) begin
                rd_en = 1'b1;
                rd_addr = right_base[AW-1:0];
                right_base_next = add_sum;
                state_next = cle_pkg::S_SHIFT_R;
              end
            end
            cle_pkg::KEY_DELETE: begin
              if (left_count != '0) begin
                left_count_next = add_sum;
              end
            end
            default: begin
              if (left_count < right_base) begin
                wr_en = 1'b1;
                left_count_next = add_sum;
              end else begin
                dropped_flag_next = 1'b1;
              end
            end
          endcase
        end
      end
      cle_pkg::S_SHIFT_L: begin
        wr_en = 1'b1;
        wr_addr = add_sum[AW-1:0];
        wr_data = rd_data;
        right_base_next = add_sum;
        state_next = cle_pkg::S_IDLE;
      end
      cle_pkg::S_SHIFT_R: begin
        wr_en = 1'b1;
        wr_data = rd_data;
        left_count_next = add_sum;
        state_next = cle_pkg::S_IDLE;
      end
      cle_pkg::S_FETCH: begin
        if (!on_right && idx == left_count) begin
          idx_next = right_base;
          on_right_next = 1'b1;
        end else if (on_right && idx == DEPTH_C) begin
          state_next = cle_pkg::S_CLOSE;
        end else begin
          rd_en = 1'b1;
          rd_addr = idx[AW-1:0];
          idx_next = add_sum;
          state_next = cle_pkg::S_EMIT;
        end
      end
      cle_pkg::S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_next = cle_pkg::S_FETCH;
        end
      end
      cle_pkg::S_CLOSE: begin
        if (out_free) begin
          load_out = 1'b1;
          char_out_next = cle_pkg::KEY_NEWLINE;
          last_next = 1'b1;
          overflow_next = dropped_flag;
          left_count_next = '0;
          right_base_next = DEPTH_C;
          dropped_flag_next = 1'b0;
          state_next = cle_pkg::S_IDLE;
        end
      end
      default: state_next = cle_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cle_pkg::S_IDLE;
      left_count <= '0;
      right_base <= DEPTH_C;
      dropped_flag <= 1'b0;
      idx <= '0;
      on_right <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      left_count <= left_count_next;
      right_base <= right_base_next;
      dropped_flag <= dropped_flag_next;
      idx <= idx_next;
      on_right <= on_right_next;
      if (load_out) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      char_out <= char_out_next;
      last <= last_next;
      overflow <= overflow_next;
    end
  end

  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    left_count <= right_base && right_base <= DEPTH_C)
    else $error("gap buffer bounds broken");

  a_close_item: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_CLOSE && out_free) |=>
      (char_valid && last && left_count == '0 && right_base == DEPTH_C))
    else $error("closing item not loaded or line not cleared");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(dropped_flag) |-> $past(left_count) == $past(right_base))
    else $error("insert dropped while buffer had room");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_EMIT && out_free) |=> (char_valid && !last))
    else $error("character item not loaded");

endmodule

`default_nettype wire

>>> design/cle_ram.sv
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
